FILE: rtl/metp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// metp_pkg
// Types, constants and fixed-point helpers for the escape-time pixel block.
// ----------------------------------------------------------------------------
package metp_pkg;

    localparam int FRAC_BITS = 26;
    localparam int FX_W      = FRAC_BITS + 6;
    localparam int PROD_W    = 2 * FX_W;

    localparam int PIX_W     = 12;
    localparam int CFG_W     = 13;
    localparam int ITER_W    = 8;
    localparam int CIDX_W    = 2;
    localparam int DIFF_W    = CFG_W + 2;
    localparam int MAG_W     = CFG_W + 3;
    localparam int DEN_W     = CFG_W + 1;
    localparam int DIV_W     = MAG_W + FRAC_BITS;
    localparam int DCNT_W    = $clog2(DIV_W);

    localparam int IN_W      = 2 * PIX_W;
    localparam int OUT_W     = 40;

    localparam logic [CIDX_W-1:0] REG_WIDTH    = 2'd0;
    localparam logic [CIDX_W-1:0] REG_HEIGHT   = 2'd1;
    localparam logic [CIDX_W-1:0] REG_MAX_ITER = 2'd2;

    localparam logic [CFG_W-1:0]  WIDTH_RST    = CFG_W'(1920);
    localparam logic [CFG_W-1:0]  HEIGHT_RST   = CFG_W'(1080);
    localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(100);

    localparam logic [31:0] COLOR_INSIDE  = 32'hFF00FF00;
    localparam logic [31:0] COLOR_ESCAPED = 32'hFFFF00FF;

    typedef logic signed [FX_W-1:0] t_fx;

    localparam t_fx FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
    localparam t_fx FX_MIN = {1'b1, {(FX_W-1){1'b0}}};
    localparam logic [PROD_W-1:0] FX_LIM = PROD_W'(1) << (FX_W - 1);

    typedef struct packed {
        logic [CFG_W-1:0]  width;
        logic [CFG_W-1:0]  height;
        logic [ITER_W-1:0] max_iter;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        t_fx  a;
        t_fx  b;
        logic dbl;
    } t_mul_req;

    typedef struct packed {
        logic              valid;
        logic [ITER_W-1:0] count;
        logic              in_set;
    } t_result;

    // signed fixed-point value from a magnitude and a sign, clamped to Q range
    function automatic t_fx fx_from_mag(input logic [PROD_W-1:0] mag, input logic neg);
        logic sat;
        t_fx  r;
        sat = (mag >= FX_LIM);
        if (neg) begin
            r = sat ? FX_MIN : -t_fx'(mag[FX_W-1:0]);
        end else begin
            r = sat ? FX_MAX : t_fx'(mag[FX_W-1:0]);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/mandelbrot_escape_time_pixel_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_top
// Escape-time evaluator for one pixel coordinate per request.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel request: column in tdata[11:0], row in
//   tdata[23:12]. m_axis returns one result per request: iteration count in
//   tdata[7:0], ARGB colour in tdata[39:8], inside flag on tuser.
//   The cfg channel writes image_width (index 0), image_height (index 1) and
//   max_iterations (index 2); other indexes are ignored. Write it only while
//   no request is in flight.
// Timing:
//   Two serial divisions of one quotient bit per cycle map the pixel to c;
//   each iteration then runs on the single shared multiplier (three
//   products and an update).
//   s_axis_tready is low while a request is worked on; one result waits in
//   an output register, so the next request is taken while it is stalled.
// Reset:
//   Synchronous, active low: registers return to 1920 x 1080 and a limit of
//   100, and any request in flight is dropped.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_top (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire [metp_pkg::IN_W-1:0]      s_axis_tdata,   // pixel_column, pixel_row
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    output logic [metp_pkg::OUT_W-1:0]    m_axis_tdata,   // escape_count, pixel_color
    output logic                          m_axis_tuser,   // inside_set
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire [metp_pkg::CIDX_W-1:0]    i_cfg_index,
    input  wire [metp_pkg::CFG_W-1:0]     i_cfg_data
);
    import metp_pkg::*;

    t_cfg              r_cfg;
    t_result           core_res;
    logic              core_ready;
    logic              core_start;
    logic              res_take;

    logic              r_out_valid;
    logic [ITER_W-1:0] r_out_count;
    logic              r_out_inside;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width    <= WIDTH_RST;
            r_cfg.height   <= HEIGHT_RST;
            r_cfg.max_iter <= MAX_ITER_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_WIDTH: begin
                    r_cfg.width <= i_cfg_data;
                end
                REG_HEIGHT: begin
                    r_cfg.height <= i_cfg_data;
                end
                REG_MAX_ITER: begin
                    r_cfg.max_iter <= i_cfg_data[ITER_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign s_axis_tready = core_ready;
    assign core_start    = s_axis_tvalid && core_ready;
    assign res_take      = !r_out_valid || m_axis_tready;

    metp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start     (core_start),
        .i_col       (s_axis_tdata[PIX_W-1:0]),
        .i_row       (s_axis_tdata[2*PIX_W-1:PIX_W]),
        .o_ready     (core_ready),
        .o_res       (core_res),
        .i_res_ready (res_take)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_res.valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_res.valid && res_take) begin
            r_out_count  <= core_res.count;
            r_out_inside <= core_res.in_set;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_inside;
    assign m_axis_tdata  = {(r_out_inside ? COLOR_INSIDE : COLOR_ESCAPED), r_out_count};

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while previous one in flight");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (core_res.valid && res_take) |=> m_axis_tvalid)
        else $error("result lost on hand-over to output register");
`endif

endmodule
`default_nettype wire

FILE: rtl/metp_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// metp_div
// Serial restoring divider: one quotient bit per cycle, dividend scaled by
// the fraction width.
// ----------------------------------------------------------------------------
module metp_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  metp_pkg::t_div_req  i_req,
    output metp_pkg::t_div_rsp  o_rsp
);
    import metp_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_q;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    always_comb begin
        trial = {r_rem, r_q[DIV_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= {i_req.dividend, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_q   <= {r_q[DIV_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

`ifndef SYNTH
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");
`endif

endmodule
`default_nettype wire

FILE: rtl/metp_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// metp_mul
// Shared fixed-point multiplier: registered magnitude product, then shift
// and clamp to the signed fixed-point range.
// ----------------------------------------------------------------------------
module metp_mul (
    input  wire                 i_clk,
    input  metp_pkg::t_mul_req  i_req,
    output metp_pkg::t_fx       o_res
);
    import metp_pkg::*;

    logic [FX_W-1:0]   ua;
    logic [FX_W-1:0]   ub;
    logic [PROD_W-1:0] r_prod;
    logic              r_neg;
    logic              r_dbl;
    logic [PROD_W-1:0] shifted;

    always_comb begin
        ua = i_req.a[FX_W-1] ? FX_W'(-i_req.a) : FX_W'(i_req.a);
        ub = i_req.b[FX_W-1] ? FX_W'(-i_req.b) : FX_W'(i_req.b);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(ua) * PROD_W'(ub);
        r_neg  <= i_req.a[FX_W-1] ^ i_req.b[FX_W-1];
        r_dbl  <= i_req.dbl;
    end

    always_comb begin
        shifted = r_dbl ? (r_prod >> (FRAC_BITS - 1)) : (r_prod >> FRAC_BITS);
        o_res   = fx_from_mag(shifted, r_neg);
    end

endmodule
`default_nettype wire

FILE: rtl/metp_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// metp_core
// Sequencer: maps the pixel to c through the divider, then runs the
// escape-time loop on the shared multiplier.
// ----------------------------------------------------------------------------
module metp_core (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  metp_pkg::t_cfg            i_cfg,
    input  wire                       i_start,
    input  wire [metp_pkg::PIX_W-1:0] i_col,
    input  wire [metp_pkg::PIX_W-1:0] i_row,
    output logic                      o_ready,
    output metp_pkg::t_result         o_res,
    input  wire                       i_res_ready
);
    import metp_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV_RE = 3'd1;
    localparam logic [2:0] S_DIV_IM = 3'd2;
    localparam logic [2:0] S_XX     = 3'd3;
    localparam logic [2:0] S_YY     = 3'd4;
    localparam logic [2:0] S_XY     = 3'd5;
    localparam logic [2:0] S_STEP   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    localparam logic [FX_W:0] BAIL = (FX_W+1)'(5) << FRAC_BITS;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [ITER_W-1:0] r_count;
    logic [ITER_W-1:0] n_count;

    logic              r_re_neg;
    logic              r_im_neg;
    logic [MAG_W-1:0]  r_im_mag;
    logic [DEN_W-1:0]  r_den;
    t_fx               r_c_re;
    t_fx               r_c_im;
    t_fx               r_x;
    t_fx               r_y;
    t_fx               r_x2;
    t_fx               r_y2;

    logic [CFG_W-1:0]         w_eff;
    logic signed [DIFF_W-1:0] d_re;
    logic signed [DIFF_W-1:0] d_im;
    logic [DIFF_W-1:0]        a_re;
    logic [DIFF_W-1:0]        a_im;
    logic [MAG_W-1:0]         m_re;
    logic [MAG_W-1:0]         m_im;

    t_div_req          div_req;
    t_div_rsp          div_rsp;
    t_mul_req          mul_req;
    t_fx               mul_res;
    t_fx               div_fx;

    logic [FX_W:0]            mag2;
    logic                     stop;
    logic signed [FX_W+1:0]   sum_x;
    logic signed [FX_W+1:0]   sum_y;
    t_fx                      nx;
    t_fx                      ny;

    function automatic t_fx sat_wide(input logic signed [FX_W+1:0] v);
        t_fx r;
        if (v > (FX_W+2)'(FX_MAX)) begin
            r = FX_MAX;
        end else if (v < (FX_W+2)'(FX_MIN)) begin
            r = FX_MIN;
        end else begin
            r = v[FX_W-1:0];
        end
        return r;
    endfunction

    // pixel to scaled offset magnitudes
    always_comb begin
        w_eff = (i_cfg.width == '0) ? CFG_W'(1) : i_cfg.width;
        d_re  = signed'(DIFF_W'({i_col, 1'b0})) - signed'(DIFF_W'(i_cfg.width));
        d_im  = signed'(DIFF_W'({i_row, 1'b0})) - signed'(DIFF_W'(i_cfg.height));
        a_re  = d_re[DIFF_W-1] ? DIFF_W'(-d_re) : DIFF_W'(d_re);
        a_im  = d_im[DIFF_W-1] ? DIFF_W'(-d_im) : DIFF_W'(d_im);
        m_re  = (MAG_W'(a_re) << 2) + MAG_W'(a_re);
        m_im  = (MAG_W'(a_im) << 2) + MAG_W'(a_im);
    end

    always_comb begin
        div_req.start    = ((r_state == S_IDLE) && i_start)
                        || ((r_state == S_DIV_RE) && div_rsp.done);
        div_req.dividend = (r_state == S_IDLE) ? m_re : r_im_mag;
        div_req.divisor  = (r_state == S_IDLE) ? {w_eff, 1'b0} : r_den;
        div_fx = fx_from_mag(PROD_W'(div_rsp.quot),
                             (r_state == S_DIV_RE) ? r_re_neg : r_im_neg);
    end

    always_comb begin
        mul_req.a   = r_x;
        mul_req.b   = (r_state == S_YY) ? r_y : r_x;
        mul_req.dbl = 1'b0;
        case (r_state)
            S_YY: begin
                mul_req.a = r_y;
            end
            S_XY: begin
                mul_req.b   = r_y;
                mul_req.dbl = 1'b1;
            end
            default: begin
                mul_req.a = r_x;
            end
        endcase
    end

    always_comb begin
        mag2  = {1'b0, r_x2} + {1'b0, r_y2};
        stop  = (mag2 > BAIL) || (r_count >= i_cfg.max_iter);
        sum_x = (FX_W+2)'(r_x2) - (FX_W+2)'(r_y2) + (FX_W+2)'(r_c_re);
        sum_y = (FX_W+2)'(mul_res) + (FX_W+2)'(r_c_im);
        nx    = sat_wide(sum_x);
        ny    = sat_wide(sum_y);
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DIV_RE;
                end
            end
            S_DIV_RE: begin
                if (div_rsp.done) begin
                    n_state = S_DIV_IM;
                end
            end
            S_DIV_IM: begin
                if (div_rsp.done) begin
                    n_state = S_XX;
                    n_count = '0;
                end
            end
            S_XX: begin
                n_state = S_YY;
            end
            S_YY: begin
                n_state = S_XY;
            end
            S_XY: begin
                n_state = S_STEP;
            end
            S_STEP: begin
                if (stop) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_XX;
                    n_count = r_count + 1'b1;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_start) begin
            r_re_neg <= d_re[DIFF_W-1];
            r_im_neg <= d_im[DIFF_W-1];
            r_im_mag <= m_im;
            r_den    <= {w_eff, 1'b0};
        end
        if ((r_state == S_DIV_RE) && div_rsp.done) begin
            r_c_re <= div_fx;
        end
        if ((r_state == S_DIV_IM) && div_rsp.done) begin
            r_c_im <= div_fx;
            r_x    <= '0;
            r_y    <= '0;
        end
        if (r_state == S_YY) begin
            r_x2 <= mul_res;
        end
        if (r_state == S_XY) begin
            r_y2 <= mul_res;
        end
        if ((r_state == S_STEP) && !stop) begin
            r_x <= nx;
            r_y <= ny;
        end
    end

    metp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    metp_mul u_mul (
        .i_clk (i_clk),
        .i_req (mul_req),
        .o_res (mul_res)
    );

    assign o_ready      = (r_state == S_IDLE);
    assign o_res.valid  = (r_state == S_DONE);
    assign o_res.count  = r_count;
    assign o_res.in_set = (r_count >= i_cfg.max_iter);

`ifndef SYNTH
    a_squares_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (!r_x2[FX_W-1] && !r_y2[FX_W-1]))
        else $error("negative square from shared multiplier");
`endif

endmodule
`default_nettype wire
